[rtl/core/ptc_pkg.sv]
// ptc_pkg: shared constants and types for the prescaled timer counter.
// Register offsets, request kinds, control word fields, prescaler status.
// No dependencies.
package ptc_pkg;

    localparam int unsigned AddrWidth  = 10;
    localparam int unsigned DataWidth  = 32;
    localparam int unsigned FuncWidth  = 2;
    localparam int unsigned PhaseWidth = 8;
    localparam int unsigned PtvWidth   = 3;

    // request kinds
    localparam logic [FuncWidth-1:0] FUNC_READ  = 2'd0;
    localparam logic [FuncWidth-1:0] FUNC_WRITE = 2'd1;
    localparam logic [FuncWidth-1:0] FUNC_TICK  = 2'd2;

    // register byte offsets
    localparam logic [AddrWidth-1:0] OFS_IDENT = 10'h000;
    localparam logic [AddrWidth-1:0] OFS_CTRL  = 10'h038;
    localparam logic [AddrWidth-1:0] OFS_COUNT = 10'h03c;
    localparam logic [AddrWidth-1:0] OFS_LOAD  = 10'h040;
    localparam logic [AddrWidth-1:0] OFS_TRIG  = 10'h044;
    localparam logic [AddrWidth-1:0] OFS_WPEND = 10'h048;

    // control word fields
    localparam int unsigned CTRL_START_BIT = 0;
    localparam int unsigned CTRL_PTV_LSB   = 2;
    localparam int unsigned CTRL_PTV_MSB   = 4;
    localparam int unsigned CTRL_PRE_BIT   = 5;

    // prescaler outcome for one tick
    typedef struct packed {
        logic                  advance;
        logic [PhaseWidth-1:0] phase_next;
    } ptc_pre_t;

endpackage

[rtl/core/ptc_if.sv]
// ptc_req_if / ptc_rsp_if: valid/ready channels of the timer.
// Depends on ptc_pkg for field widths.
interface ptc_req_if
    import ptc_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [FuncWidth-1:0] func;
    logic [AddrWidth-1:0] addr;
    logic [DataWidth-1:0] wdata;

    modport source (output valid, output func, output addr, output wdata, input ready);
    modport sink   (input valid, input func, input addr, input wdata, output ready);
endinterface

interface ptc_rsp_if
    import ptc_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [DataWidth-1:0] rdata;
    logic                 unmapped;

    modport source (output valid, output rdata, output unmapped, input ready);
    modport sink   (input valid, input rdata, input unmapped, output ready);
endinterface

[rtl/core/ptc_prescale.sv]
// ptc_prescale: prescaler phase step for one input-clock tick.
// Depends on ptc_pkg.
module ptc_prescale
    import ptc_pkg::*;
(
    input  logic                  pre_en,
    input  logic [PtvWidth-1:0]   ptv,
    input  logic [PhaseWidth-1:0] phase,
    output ptc_pre_t              status
);

    logic [PhaseWidth:0] phase_inc;
    logic [PhaseWidth:0] divisor;

    assign phase_inc = {1'b0, phase} + {{PhaseWidth{1'b0}}, 1'b1};
    assign divisor   = {{(PhaseWidth-1){1'b0}}, 2'b10} << ptv;

    always_comb
    begin
        status.advance    = 1'b1;
        status.phase_next = phase;
        if (pre_en)
        begin
            if (phase_inc >= divisor)
            begin
                status.phase_next = '0;
            end
            else
            begin
                status.advance    = 1'b0;
                status.phase_next = phase_inc[PhaseWidth-1:0];
            end
        end
    end

endmodule

[rtl/core/prescaled_timer_counter_regs.sv]
// prescaled_timer_counter_regs: timer with a register interface.
// Depends on ptc_pkg, ptc_req_if / ptc_rsp_if and ptc_prescale.
//
//  channel | dir | payload                      | carries
//  --------+-----+------------------------------+----------------------------------
//  req     | in  | func[1:0] addr[9:0] wdata[31:0] | bus read, bus write or one tick
//  rsp     | out | rdata[31:0] unmapped         | one response for each bus read
//
// One request per cycle while rsp is not stalled. Each request updates the timer
// state in the cycle it is accepted; a read's response appears in the output
// register on the next cycle. The 32-bit counter increment sets the critical path.
// Reset clears all registers but run, which it sets, and rdata/unmapped, which it
// leaves as they are; the counter runs after reset (start bit reads 0).
// A pending response only blocks new requests while rsp is stalled; with the
// response taken in the same cycle a new request is still accepted.
module prescaled_timer_counter_regs
    import ptc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    ptc_req_if.sink   req,
    ptc_rsp_if.source rsp
);

    // architectural state
    logic [DataWidth-1:0]  ctrl_reg,  ctrl_next;
    logic [DataWidth-1:0]  load_reg,  load_next;
    logic [DataWidth-1:0]  count_reg, count_next;
    logic                  run_reg,   run_next;
    logic [PhaseWidth-1:0] phase_reg, phase_next;

    // response register
    logic                  rsp_valid_reg, rsp_valid_next;
    logic [DataWidth-1:0]  rdata_reg,     rdata_next;
    logic                  unmapped_reg,  unmapped_next;

    logic     req_accept;
    ptc_pre_t pre_status;

    // output slot frees when empty or being drained this cycle
    assign req.ready  = !rsp_valid_reg || rsp.ready;
    assign req_accept = req.valid && req.ready;

    assign rsp.valid    = rsp_valid_reg;
    assign rsp.rdata    = rdata_reg;
    assign rsp.unmapped = unmapped_reg;

    ptc_prescale u_prescale (
        .pre_en (ctrl_reg[CTRL_PRE_BIT]),
        .ptv    (ctrl_reg[CTRL_PTV_MSB:CTRL_PTV_LSB]),
        .phase  (phase_reg),
        .status (pre_status)
    );

    always_comb
    begin
        ctrl_next      = ctrl_reg;
        load_next      = load_reg;
        count_next     = count_reg;
        run_next       = run_reg;
        phase_next     = phase_reg;
        rdata_next     = rdata_reg;
        unmapped_next  = unmapped_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;

        if (req_accept)
        begin
            unique case (req.func)
                FUNC_READ:
                begin
                    rsp_valid_next = 1'b1;
                    unmapped_next  = 1'b0;
                    unique case (req.addr)
                        OFS_IDENT: rdata_next = '0;
                        OFS_CTRL:  rdata_next = ctrl_reg;
                        OFS_COUNT: rdata_next = count_reg;
                        OFS_LOAD:  rdata_next = load_reg;
                        OFS_WPEND: rdata_next = '0;
                        default:
                        begin
                            rdata_next    = '0;
                            unmapped_next = 1'b1;
                        end
                    endcase
                end
                FUNC_WRITE:
                begin
                    unique case (req.addr)
                        OFS_CTRL:
                        begin
                            ctrl_next  = req.wdata;
                            run_next   = req.wdata[CTRL_START_BIT];
                            phase_next = '0;
                        end
                        OFS_COUNT:
                        begin
                            count_next = req.wdata;
                            phase_next = '0;
                        end
                        OFS_LOAD:
                        begin
                            load_next = req.wdata;
                        end
                        OFS_TRIG:
                        begin
                            count_next = load_reg;
                            phase_next = '0;
                        end
                        default:
                        begin
                            // identity, write-pending and holes ignore writes
                        end
                    endcase
                end
                FUNC_TICK:
                begin
                    if (run_reg)
                    begin
                        phase_next = pre_status.phase_next;
                        if (pre_status.advance)
                        begin
                            count_next = count_reg + {{(DataWidth-1){1'b0}}, 1'b1};
                        end
                    end
                end
                default:
                begin
                    // spare code: no effect
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg      <= '0;
            load_reg      <= '0;
            count_reg     <= '0;
            run_reg       <= 1'b1;
            phase_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            ctrl_reg      <= ctrl_next;
            load_reg      <= load_next;
            count_reg     <= count_next;
            run_reg       <= run_next;
            phase_reg     <= phase_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg    <= rdata_next;
        unmapped_reg <= unmapped_next;
    end

    // prescaler phase never reaches the current divisor
    a_phase_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, phase_reg} <
         ({{(PhaseWidth-1){1'b0}}, 2'b10} << ctrl_reg[CTRL_PTV_MSB:CTRL_PTV_LSB])))
        else $error("prescaler phase out of range");

    // an accepted read always yields a response next cycle
    a_read_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        (req_accept && req.func == FUNC_READ) |=> rsp_valid_reg)
        else $error("read request lost");

    // non-read into an empty slot creates no response
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        (req_accept && req.func != FUNC_READ && !rsp_valid_reg) |=> !rsp_valid_reg)
        else $error("response without a read");

    // a tick while stopped leaves counter and phase untouched
    a_stopped_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (req_accept && req.func == FUNC_TICK && !run_reg)
        |=> ($stable(count_reg) && $stable(phase_reg)))
        else $error("stopped timer advanced");

endmodule
